/* src/arm_dp_pkg.sv */
package arm_dp_pkg;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned SHAMT_BITS = 8;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13
    } alu_op_t;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } shift_kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOT_DP = 2'd1,
        ST_BAD_OP = 2'd2
    } alu_status_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] result;
        logic                 write_enable;
        logic [3:0]           dest_index;
        logic                 set_flags;
        logic                 flag_n;
        logic                 flag_z;
        logic                 flag_c;
        alu_status_t          status;
    } alu_rsp_t;

endpackage

/* src/arm_dp_if.sv */
interface arm_dp_cmd_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    logic [31:0] first_operand;
    logic [31:0] shift_source;
    logic [7:0]  shift_count_value;
    logic        carry_in;

    modport source (
        output valid, instruction, first_operand, shift_source, shift_count_value, carry_in,
        input  ready
    );
    modport sink (
        input  valid, instruction, first_operand, shift_source, shift_count_value, carry_in,
        output ready
    );
endinterface

interface arm_dp_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        write_enable;
    logic [3:0]  dest_index;
    logic        set_flags;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic [1:0]  status;

    modport source (
        output valid, result, write_enable, dest_index, set_flags, flag_n, flag_z, flag_c,
               status,
        input  ready
    );
    modport sink (
        input  valid, result, write_enable, dest_index, set_flags, flag_n, flag_z, flag_c,
               status,
        output ready
    );
endinterface

/* src/arm_data_processing_alu_unit.sv */
// channel  dir  payload                                              handshake
// cmd      in   instruction, first_operand, shift_source,            valid/ready
//               shift_count_value, carry_in
// rsp      out  result, write_enable, dest_index, set_flags,         valid/ready
//               flag_n, flag_z, flag_c, status
//
// one instruction per cycle unless rsp stalls; each beat first sits in the input
// register, where shifter and adder work, and then in the result register
// rst_n clears both valid flags asynchronously; payload registers are not reset
// a stalled rsp holds the result register, and the input register still takes a
// beat while it is empty, so cmd only stalls when both stages are full
module arm_data_processing_alu_unit
    import arm_dp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    arm_dp_cmd_if.sink   cmd,
    arm_dp_rsp_if.source rsp
);

    logic                  s1_valid_reg;
    logic [WORD_BITS-1:0]  instr_reg;
    logic [WORD_BITS-1:0]  op1_reg;
    logic [WORD_BITS-1:0]  rm_reg;
    logic [SHAMT_BITS-1:0] rs_reg;
    logic                  cin_reg;

    logic                  out_valid_reg;
    alu_rsp_t              rsp_reg;
    alu_rsp_t              rsp_next;

    logic                  out_free;
    logic                  s1_free;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_free   = !s1_valid_reg || out_free;
    assign cmd.ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && cmd.valid)
        begin
            instr_reg <= cmd.instruction;
            op1_reg   <= cmd.first_operand;
            rm_reg    <= cmd.shift_source;
            rs_reg    <= cmd.shift_count_value;
            cin_reg   <= cmd.carry_in;
        end
    end

    // barrel shifter, operand 2 and alu
    always_comb
    begin
        logic [SHAMT_BITS-1:0]  shamt;
        logic [4:0]             amt5;
        logic                   big;
        logic                   at32;
        logic [WORD_BITS:0]     lsl_w;
        logic [WORD_BITS:0]     lsr_w;
        logic signed [WORD_BITS:0] asr_w;
        logic [2*WORD_BITS-1:0] ror_w;
        logic [2*WORD_BITS-1:0] imm_w;
        logic [4:0]             imm_rot;
        logic [WORD_BITS-1:0]   op2;
        logic                   sh_c;
        logic                   sign;
        logic [WORD_BITS:0]     sum;
        alu_op_t                op;

        shamt   = instr_reg[4] ? rs_reg : {3'b000, instr_reg[11:7]};
        amt5    = shamt[4:0];
        big     = |shamt[SHAMT_BITS-1:5];
        at32    = (shamt == SHAMT_BITS'(WORD_BITS));
        sign    = rm_reg[WORD_BITS-1];
        lsl_w   = {1'b0, rm_reg} << amt5;
        lsr_w   = {rm_reg, 1'b0} >> amt5;
        asr_w   = $signed({rm_reg, 1'b0}) >>> amt5;
        ror_w   = {rm_reg, rm_reg} >> amt5;
        imm_rot = {instr_reg[11:8], 1'b0};
        imm_w   = {24'd0, instr_reg[7:0], 24'd0, instr_reg[7:0]} >> imm_rot;
        op      = alu_op_t'(instr_reg[24:21]);

        op2  = rm_reg;
        sh_c = cin_reg;
        if (instr_reg[25])
        begin
            op2  = imm_w[WORD_BITS-1:0];
            sh_c = (imm_rot == 5'd0) ? cin_reg : op2[WORD_BITS-1];
        end
        else if (shamt != '0)
        begin
            case (shift_kind_t'(instr_reg[6:5]))
                SH_LSL:
                begin
                    op2  = big ? '0 : lsl_w[WORD_BITS-1:0];
                    sh_c = big ? (at32 & rm_reg[0]) : lsl_w[WORD_BITS];
                end
                SH_LSR:
                begin
                    op2  = big ? '0 : lsr_w[WORD_BITS:1];
                    sh_c = big ? (at32 & sign) : lsr_w[0];
                end
                SH_ASR:
                begin
                    op2  = big ? {WORD_BITS{sign}} : asr_w[WORD_BITS:1];
                    sh_c = big ? sign : asr_w[0];
                end
                default:
                begin
                    // a rotation by a multiple of 32 leaves rm, carry is its sign
                    op2  = ror_w[WORD_BITS-1:0];
                    sh_c = op2[WORD_BITS-1];
                end
            endcase
        end

        sum      = '0;
        rsp_next = '0;
        rsp_next.flag_c = sh_c;
        rsp_next.status = ST_OK;

        case (op)
            OP_AND, OP_TST: rsp_next.result = op1_reg & op2;
            OP_EOR, OP_TEQ: rsp_next.result = op1_reg ^ op2;
            OP_ORR:         rsp_next.result = op1_reg | op2;
            OP_MOV:         rsp_next.result = op2;
            OP_SUB, OP_CMP:
            begin
                sum = {1'b0, op1_reg} + {1'b0, ~op2} + (WORD_BITS+1)'(1);
                rsp_next.result = sum[WORD_BITS-1:0];
                rsp_next.flag_c = sum[WORD_BITS];
            end
            OP_RSB:
            begin
                sum = {1'b0, op2} + {1'b0, ~op1_reg} + (WORD_BITS+1)'(1);
                rsp_next.result = sum[WORD_BITS-1:0];
                rsp_next.flag_c = sum[WORD_BITS];
            end
            OP_ADD:
            begin
                sum = {1'b0, op1_reg} + {1'b0, op2};
                rsp_next.result = sum[WORD_BITS-1:0];
                rsp_next.flag_c = sum[WORD_BITS];
            end
            default:
            begin
                rsp_next.flag_c = 1'b0;
                rsp_next.status = ST_BAD_OP;
            end
        endcase

        rsp_next.write_enable = !(op inside {OP_TST, OP_TEQ, OP_CMP});
        rsp_next.dest_index   = instr_reg[15:12];
        rsp_next.set_flags    = instr_reg[20];
        rsp_next.flag_n       = rsp_next.result[WORD_BITS-1];
        rsp_next.flag_z       = (rsp_next.result == '0);

        // anything but a clean data-processing word reports status alone
        if (instr_reg[27:26] != 2'b00)
        begin
            rsp_next        = '0;
            rsp_next.status = ST_NOT_DP;
        end
        else if (rsp_next.status == ST_BAD_OP)
        begin
            rsp_next        = '0;
            rsp_next.status = ST_BAD_OP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result       = rsp_reg.result;
    assign rsp.write_enable = rsp_reg.write_enable;
    assign rsp.dest_index   = rsp_reg.dest_index;
    assign rsp.set_flags    = rsp_reg.set_flags;
    assign rsp.flag_n       = rsp_reg.flag_n;
    assign rsp.flag_z       = rsp_reg.flag_z;
    assign rsp.flag_c       = rsp_reg.flag_c;
    assign rsp.status       = rsp_reg.status;

    // an error beat carries nothing but its status
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |->
            rsp.result == '0 && !rsp.write_enable && !rsp.set_flags && !rsp.flag_c)
        else $error("error beat with non-zero payload");

    // a full pipe under a stalled rsp must keep its input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !rsp.ready |=> s1_valid_reg && $stable(instr_reg))
        else $error("input stage lost a beat under stall");

    // the result register only moves when the previous beat has gone
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(rsp_reg))
        else $error("result register overwritten while stalled");

    // a status-ok beat has flags that agree with its result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_OK |->
            rsp.flag_z == (rsp.result == '0) && rsp.flag_n == rsp.result[WORD_BITS-1])
        else $error("n or z flag disagrees with result");

endmodule

/* tb/arm_data_processing_alu_unit_test.sv */
`timescale 1ns / 100ps

module arm_data_processing_alu_unit_test;
    import arm_dp_pkg::*;

    localparam int ITEMS_PER_PHASE = 325;
    localparam int STALL_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 8;
    localparam int REPORT_LIMIT    = 10;

    localparam int SEND_IDLE [3] = '{14, 71, 0};
    localparam int RECV_IDLE [3] = '{71, 14, 0};

    localparam logic [3:0] COND_AL  = 4'hE;
    localparam logic [1:0] CLASS_DP = 2'b00;

    // opcodes the unit does not implement
    localparam logic [3:0] OPC_ADC = 4'd5;
    localparam logic [3:0] OPC_SBC = 4'd6;
    localparam logic [3:0] OPC_RSC = 4'd7;
    localparam logic [3:0] OPC_CMN = 4'd11;
    localparam logic [3:0] OPC_BIC = 4'd14;
    localparam logic [3:0] OPC_MVN = 4'd15;

    localparam logic [3:0] UNSUP_OPS [6] = '{OPC_ADC, OPC_SBC, OPC_RSC,
                                             OPC_CMN, OPC_BIC, OPC_MVN};
    localparam alu_op_t DP_OPS [10] = '{OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD,
                                        OP_TST, OP_TEQ, OP_CMP, OP_ORR, OP_MOV};

    localparam alu_rsp_t NO_RSP     = '0;
    localparam alu_rsp_t RSP_NOT_DP = '{32'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                                        ST_NOT_DP};
    localparam alu_rsp_t RSP_BAD_OP = '{32'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                                        ST_BAD_OP};
    localparam alu_rsp_t RSP_MOV_ZERO = '{32'd0, 1'b1, 4'd3, 1'b1, 1'b0, 1'b1, 1'b1,
                                          ST_OK};
    localparam alu_rsp_t RSP_ADD_WRAP = '{32'd0, 1'b1, 4'd4, 1'b1, 1'b0, 1'b1, 1'b1,
                                          ST_OK};

    typedef struct {
        logic [31:0] instr;
        logic [31:0] op1;
        logic [31:0] rm;
        logic [7:0]  rs;
        logic        cin;
        logic        typed;
        alu_rsp_t    exp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    arm_dp_cmd_if cmd_bus ();
    arm_dp_rsp_if rsp_bus ();

    arm_data_processing_alu_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    always #1 clk = ~clk;

    stim_row_t directed_rows [$];
    alu_rsp_t  expected_rsp [$];

    int send_idle_pct = SEND_IDLE[0];
    int recv_idle_pct = RECV_IDLE[0];

    // expectation typed into the table for the beat now on the bus
    logic     beat_typed = 1'b0;
    alu_rsp_t beat_typed_rsp = '0;

    int fail_count      = 0;
    int beats_in        = 0;
    int results_checked = 0;
    int stall_cycles    = 0;
    int n_ok            = 0;
    int n_not_dp        = 0;
    int n_bad_op        = 0;

    function automatic logic [31:0] dp_word(logic [3:0] cond, logic imm, logic [3:0] opc,
            logic s, logic [3:0] rn, logic [3:0] rd, logic [11:0] op2f);
        return {cond, CLASS_DP, imm, opc, s, rn, rd, op2f};
    endfunction

    function automatic logic [31:0] ror32(logic [31:0] x, logic [4:0] n);
        return (n == 0) ? x : ((x >> n) | (x << (6'd32 - n)));
    endfunction

    // returns {carry out, shifted value}
    function automatic logic [32:0] barrel_shift(logic [31:0] src, shift_kind_t kind,
            logic [7:0] amount, logic cin);
        int         n;
        logic [4:0] r;
        n = int'(amount);
        r = amount[4:0];
        if (n == 0)
            return {cin, src};
        case (kind)
            SH_LSL:
                if (n < 32)
                    return {src[32 - n], src << n};
                else
                    return {(n == 32) ? src[0] : 1'b0, 32'd0};
            SH_LSR:
                if (n < 32)
                    return {src[n - 1], src >> n};
                else
                    return {(n == 32) ? src[31] : 1'b0, 32'd0};
            SH_ASR:
                if (n < 32)
                    return {src[n - 1], $signed(src) >>> n};
                else
                    return {src[31], {32{src[31]}}};
            default:
                // ror works modulo 32; a whole turn hands out bit 31 as carry
                if (r == 0)
                    return {src[31], src};
                else
                    return {src[r - 1], ror32(src, r)};
        endcase
    endfunction

    function automatic alu_rsp_t predict_alu(logic [31:0] instr, logic [31:0] op1,
            logic [31:0] rm, logic [7:0] rs, logic cin);
        alu_rsp_t    rsp;
        logic [31:0] op2;
        logic        carry;
        logic [32:0] wide;
        logic [4:0]  rot;
        rsp = '0;
        if (instr[27:26] != CLASS_DP)
        begin
            rsp.status = ST_NOT_DP;
            return rsp;
        end
        if (instr[25])
        begin
            rot = {instr[11:8], 1'b0};
            op2 = ror32({24'd0, instr[7:0]}, rot);
            carry = (rot == 0) ? cin : op2[31];
        end
        else
        begin
            // bit 7 only matters for a constant amount
            {carry, op2} = barrel_shift(rm, shift_kind_t'(instr[6:5]),
                                        instr[4] ? rs : {3'd0, instr[11:7]}, cin);
        end
        case (instr[24:21])
            OP_AND, OP_TST: rsp.result = op1 & op2;
            OP_EOR, OP_TEQ: rsp.result = op1 ^ op2;
            OP_ORR:         rsp.result = op1 | op2;
            OP_MOV:         rsp.result = op2;
            OP_SUB, OP_CMP:
            begin
                wide = {1'b0, op1} - {1'b0, op2};
                rsp.result = wide[31:0];
                carry = ~wide[32];
            end
            OP_RSB:
            begin
                wide = {1'b0, op2} - {1'b0, op1};
                rsp.result = wide[31:0];
                carry = ~wide[32];
            end
            OP_ADD:
            begin
                wide = {1'b0, op1} + {1'b0, op2};
                rsp.result = wide[31:0];
                carry = wide[32];
            end
            default:
            begin
                rsp.status = ST_BAD_OP;
                return rsp;
            end
        endcase
        rsp.write_enable = (instr[24:21] != OP_TST) && (instr[24:21] != OP_TEQ)
                           && (instr[24:21] != OP_CMP);
        rsp.dest_index = instr[15:12];
        rsp.set_flags  = instr[20];
        rsp.flag_n     = rsp.result[31];
        rsp.flag_z     = (rsp.result == 32'd0);
        rsp.flag_c     = carry;
        rsp.status     = ST_OK;
        return rsp;
    endfunction

    function automatic string rsp_text(alu_rsp_t r);
        return $sformatf("res=%h we=%b rd=%0d s=%b nzc=%b%b%b st=%0d", r.result,
                         r.write_enable, r.dest_index, r.set_flags, r.flag_n, r.flag_z,
                         r.flag_c, r.status);
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch %0d at %0t: %s", fail_count, $realtime, msg);
    endfunction

    function automatic void add_row(logic [31:0] instr, logic [31:0] op1, logic [31:0] rm,
            logic [7:0] rs, logic cin, logic typed, alu_rsp_t exp);
        stim_row_t row;
        row.instr = instr;
        row.op1   = op1;
        row.rm    = rm;
        row.rs    = rs;
        row.cin   = cin;
        row.typed = typed;
        row.exp   = exp;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(15))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // register shift amounts lean towards zero, 31 to 33, 1 to 31 and 64 to 255
    function automatic logic [7:0] pick_count();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'($urandom_range(31, 33));
            2:       return 8'($urandom_range(1, 31));
            3:       return 8'($urandom_range(64, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t  row;
        logic [3:0] opc;
        int         pick;
        pick = $urandom_range(99);
        opc = (pick < 14) ? UNSUP_OPS[$urandom_range(5)] : DP_OPS[$urandom_range(9)];
        row.instr = dp_word(4'($urandom), 1'($urandom), opc, 1'($urandom), 4'($urandom),
                            4'($urandom), 12'($urandom));
        // a few raw words, mostly outside the data-processing class
        if (pick < 6)
            row.instr = $urandom;
        row.op1   = pick_operand();
        row.rm    = pick_operand();
        row.rs    = pick_count();
        row.cin   = 1'($urandom);
        row.typed = 1'b0;
        row.exp   = NO_RSP;
        return row;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic drive_beat(input stim_row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid = 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid             = 1'b1;
        cmd_bus.instruction       = row.instr;
        cmd_bus.first_operand     = row.op1;
        cmd_bus.shift_source      = row.rm;
        cmd_bus.shift_count_value = row.rs;
        cmd_bus.carry_in          = row.cin;
        beat_typed                = row.typed;
        beat_typed_rsp            = row.exp;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        cmd_bus.valid = 1'b0;
        while (expected_rsp.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
        rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        alu_rsp_t got;
        alu_rsp_t want;
        logic     moved;
        moved = 1'b0;
        // results first, so a beat taken on the same edge cannot be matched early
        if (rsp_bus.valid && rsp_bus.ready)
        begin
            moved = 1'b1;
            got = {rsp_bus.result, rsp_bus.write_enable, rsp_bus.dest_index,
                   rsp_bus.set_flags, rsp_bus.flag_n, rsp_bus.flag_z, rsp_bus.flag_c,
                   rsp_bus.status};
            results_checked++;
            if (expected_rsp.size() == 0)
                note_failure($sformatf("result with nothing outstanding: %s",
                                       rsp_text(got)));
            else
            begin
                want = expected_rsp.pop_front();
                if (got !== want)
                    note_failure($sformatf("expected %s, got %s", rsp_text(want),
                                           rsp_text(got)));
            end
        end
        if (cmd_bus.valid && cmd_bus.ready)
        begin
            moved = 1'b1;
            beats_in++;
            if (beat_typed)
                want = beat_typed_rsp;
            else
                want = predict_alu(cmd_bus.instruction, cmd_bus.first_operand,
                                   cmd_bus.shift_source, cmd_bus.shift_count_value,
                                   cmd_bus.carry_in);
            expected_rsp.push_back(want);
            case (want.status)
                ST_OK:     n_ok++;
                ST_NOT_DP: n_not_dp++;
                default:   n_bad_op++;
            endcase
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_rsp.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        rst_n                     = 1'b0;
        cmd_bus.valid             = 1'b0;
        cmd_bus.instruction       = '0;
        cmd_bus.first_operand     = '0;
        cmd_bus.shift_source      = '0;
        cmd_bus.shift_count_value = '0;
        cmd_bus.carry_in          = 1'b0;

        // words outside the data-processing class
        add_row(32'hE591_2000, 32'h1234_5678, 32'h9ABC_DEF0, 8'd7, 1'b1, 1'b1, RSP_NOT_DP);
        add_row(32'hEA00_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b1, RSP_NOT_DP);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, RSP_NOT_DP);
        // opcodes left out of the unit
        add_row(dp_word(COND_AL, 1'b0, OPC_ADC, 1'b1, 4'd1, 4'd2, 12'h123),
                32'd5, 32'd6, 8'd1, 1'b1, 1'b1, RSP_BAD_OP);
        add_row(dp_word(COND_AL, 1'b1, OPC_SBC, 1'b0, 4'd15, 4'd15, 12'hFFF),
                32'hFFFF_FFFF, 32'd0, 8'd0, 1'b0, 1'b1, RSP_BAD_OP);
        add_row(dp_word(COND_AL, 1'b0, OPC_RSC, 1'b1, 4'd0, 4'd0, 12'h000),
                32'd0, 32'd0, 8'd0, 1'b0, 1'b1, RSP_BAD_OP);
        add_row(dp_word(COND_AL, 1'b0, OPC_CMN, 1'b1, 4'd3, 4'd4, 12'h010),
                32'h8000_0000, 32'h8000_0000, 8'd32, 1'b1, 1'b1, RSP_BAD_OP);
        add_row(dp_word(COND_AL, 1'b1, OPC_BIC, 1'b1, 4'd7, 4'd8, 12'h4FF),
                32'h7FFF_FFFF, 32'd1, 8'd255, 1'b0, 1'b1, RSP_BAD_OP);
        add_row(dp_word(4'h0, 1'b0, OPC_MVN, 1'b0, 4'd9, 4'd10, 12'hF0F),
                32'h0000_0001, 32'hFFFF_FFFF, 8'd33, 1'b1, 1'b1, RSP_BAD_OP);
        // mov of immediate zero, no rotation: carry passes through
        add_row(dp_word(COND_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd3, 12'h000),
                32'hDEAD_BEEF, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b1, RSP_MOV_ZERO);
        // add that wraps to zero
        add_row(dp_word(COND_AL, 1'b0, OP_ADD, 1'b1, 4'd1, 4'd4, {5'd0, SH_LSL, 1'b0, 4'd2}),
                32'hFFFF_FFFF, 32'd1, 8'd0, 1'b0, 1'b1, RSP_ADD_WRAP);
        // rotated immediate: 0xff ror 4
        add_row(dp_word(COND_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd5, 12'h2FF),
                32'd0, 32'd0, 8'd0, 1'b0, 1'b0, NO_RSP);
        add_row(dp_word(COND_AL, 1'b0, OP_AND, 1'b1, 4'd2, 4'd6, {5'd31, SH_LSL, 1'b0, 4'd3}),
                32'hFFFF_FFFF, 32'd3, 8'd0, 1'b0, 1'b0, NO_RSP);
        // constant amount of zero on a right shift passes rm through
        add_row(dp_word(COND_AL, 1'b0, OP_EOR, 1'b1, 4'd2, 4'd7, {5'd0, SH_LSR, 1'b0, 4'd3}),
                32'h0F0F_0F0F, 32'hFFFF_0000, 8'd0, 1'b1, 1'b0, NO_RSP);
        add_row(dp_word(COND_AL, 1'b0, OP_SUB, 1'b1, 4'd2, 4'd8, {5'd0, SH_LSL, 1'b0, 4'd3}),
                32'h8000_0000, 32'h8000_0000, 8'd0, 1'b0, 1'b0, NO_RSP);
        add_row(dp_word(COND_AL, 1'b0, OP_RSB, 1'b1, 4'd2, 4'd9, {5'd1, SH_ASR, 1'b0, 4'd3}),
                32'd1, 32'h8000_0001, 8'd0, 1'b0, 1'b0, NO_RSP);
        // compares run with the s bit clear as well as set
        add_row(dp_word(COND_AL, 1'b0, OP_TST, 1'b0, 4'd2, 4'd0, {5'd4, SH_ROR, 1'b0, 4'd3}),
                32'hF000_0000, 32'h0000_000F, 8'd0, 1'b0, 1'b0, NO_RSP);
        add_row(dp_word(COND_AL, 1'b0, OP_TEQ, 1'b1, 4'd2, 4'd0, {4'd5, 1'b0, SH_LSL, 1'b1,
                4'd3}), 32'd0, 32'h8000_0001, 8'd32, 1'b0, 1'b0, NO_RSP);
        add_row(dp_word(COND_AL, 1'b0, OP_CMP, 1'b0, 4'd2, 4'd0, {5'd0, SH_LSL, 1'b0, 4'd3}),
                32'd0, 32'd1, 8'd0, 1'b1, 1'b0, NO_RSP);
        add_row(dp_word(COND_AL, 1'b0, OP_ORR, 1'b1, 4'd2, 4'd11, {4'd5, 1'b0, SH_LSR, 1'b1,
                4'd3}), 32'h0000_0001, 32'h8000_0000, 8'd32, 1'b0, 1'b0, NO_RSP);
        add_row(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd12, {4'd5, 1'b0, SH_LSL, 1'b1,
                4'd3}), 32'd0, 32'hFFFF_FFFF, 8'd33, 1'b1, 1'b0, NO_RSP);
        add_row(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd13, {4'd5, 1'b0, SH_ASR, 1'b1,
                4'd3}), 32'd0, 32'h8000_0000, 8'd255, 1'b0, 1'b0, NO_RSP);
        add_row(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd14, {4'd5, 1'b0, SH_ROR, 1'b1,
                4'd3}), 32'd0, 32'h8000_0001, 8'd64, 1'b0, 1'b0, NO_RSP);
        // register shift with bit 7 set, which must be ignored
        add_row(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd15, {4'd5, 1'b1, SH_ROR, 1'b1,
                4'd3}), 32'd0, 32'h1234_5678, 8'd0, 1'b1, 1'b0, NO_RSP);
        add_row(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd1, {4'd5, 1'b1, SH_LSR, 1'b1,
                4'd3}), 32'd0, 32'hFFFF_FFFF, 8'd33, 1'b1, 1'b0, NO_RSP);

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            drive_beat(directed_rows[i]);
        drain_results();

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = SEND_IDLE[phase];
            recv_idle_pct = RECV_IDLE[phase];
            repeat (ITEMS_PER_PHASE)
                drive_beat(random_row());
            // hold off until the unit has handed back everything
            drain_results();
        end

        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d instructions issued (%0d from the directed table), %0d results compared",
                 beats_in, directed_rows.size(), results_checked);
        $display("status mix: %0d executed, %0d not data-processing, %0d unsupported opcode",
                 n_ok, n_not_dp, n_bad_op);
        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
src/arm_dp_pkg.sv
src/arm_dp_if.sv
src/arm_data_processing_alu_unit.sv
tb/arm_data_processing_alu_unit_test.sv
